FILE: src/imt_pkg.sv
// shared types and constants of the ip indicator match table
package imt_pkg;

	// field widths of the item channels and of the apb port
	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 16;
	localparam int PID_W   = 32;
	localparam int OP_W    = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// command codes
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	// result kinds
	localparam logic KIND_MATCH    = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

	// register word indexes
	typedef enum logic [1:0] {
		REG_FEED_LOADED = 2'd0,
		REG_PID_FILTER  = 2'd1,
		REG_FILTER_PID  = 2'd2
	} reg_idx_t;

	// configuration as seen by the lookup engine
	typedef struct packed {
		logic             feed_loaded;
		logic             pid_filter_enable;
		logic [PID_W-1:0] filter_pid;
	} cfg_t;

	// engine control states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

FILE: src/imt_cmd_if.sv
// command item channel: clear, insert and query items
interface imt_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [imt_pkg::OP_W-1:0]    opcode;
	logic [imt_pkg::ADDR_W-1:0]  entry_address;
	logic                        entry_valid;
	logic [imt_pkg::TAG_W-1:0]   entry_tag;
	logic [imt_pkg::ADDR_W-1:0]  conn_address;
	logic                        conn_address_valid;
	logic [imt_pkg::PID_W-1:0]   conn_pid;
	logic [imt_pkg::TAG_W-1:0]   conn_tag;

	modport source (
		output valid, opcode, entry_address, entry_valid, entry_tag,
		output conn_address, conn_address_valid, conn_pid, conn_tag,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_address, entry_valid, entry_tag,
		input  conn_address, conn_address_valid, conn_pid, conn_tag,
		output ready
	);
endinterface

FILE: src/imt_res_if.sv
// result item channel: matches and overflow reports
interface imt_res_if;
	logic                      valid;
	logic                      ready;
	logic                      result_kind;
	logic [imt_pkg::TAG_W-1:0] match_conn_tag;
	logic [imt_pkg::TAG_W-1:0] match_entry_tag;
	logic                      last_result;

	modport source (
		output valid, result_kind, match_conn_tag, match_entry_tag, last_result,
		input  ready
	);
	modport sink (
		input  valid, result_kind, match_conn_tag, match_entry_tag, last_result,
		output ready
	);
endinterface

FILE: src/imt_ram.sv
// generic single write port ram with one registered read port
module imt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/imt_regs.sv
// apb configuration registers of the match table
module imt_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [imt_pkg::PADDR_W-1:0]   paddr,
	input  logic [imt_pkg::PDATA_W-1:0]   pwdata,
	output logic [imt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output imt_pkg::cfg_t                 cfg
);

	imt_pkg::cfg_t     cfg_q;
	imt_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = imt_pkg::reg_idx_t'(paddr[imt_pkg::PADDR_W-1:2]);
	assign cfg    = cfg_q;

	// register writes, unknown words ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				imt_pkg::REG_FEED_LOADED: cfg_q.feed_loaded       <= pwdata[0];
				imt_pkg::REG_PID_FILTER:  cfg_q.pid_filter_enable <= pwdata[0];
				imt_pkg::REG_FILTER_PID:  cfg_q.filter_pid        <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			imt_pkg::REG_FEED_LOADED: prdata[0] = cfg_q.feed_loaded;
			imt_pkg::REG_PID_FILTER:  prdata[0] = cfg_q.pid_filter_enable;
			imt_pkg::REG_FILTER_PID:  prdata    = cfg_q.filter_pid;
			default: ;
		endcase
	end

endmodule

FILE: src/ip_indicator_match_table.sv
// ip indicator match table: ipv4 indicator store with in-order lookup
//
// cmd channel takes clear, insert and query items; res channel returns
// match results and overflow reports; an apb port sets feed_loaded,
// pid_filter_enable and filter_pid.
// clear and insert items leave the engine idle; the next item can be taken
// in the following cycle. a valid insert into a full table leaves one
// overflow result marked last, passed out of the pending slot by the flush.
// a query passing the feed, count, valid and pid checks reads the stored
// entries from one ram, one entry per cycle unless a hit stalls, in
// insertion order, and ends with a flush when anything hit; a query that
// fails the checks leaves the engine idle and returns no result.
// each hit waits in a pending slot until the next hit or the end of the
// scan, so that the final one can be marked last when the scan ends.
// entry addresses and tags live in the ram; no clearing pass is needed,
// since only entries below the count are ever read.
// reset empties the table, clears control and apb registers, keeps the ram.
// when the receiver stalls, the output register holds its item and the
// scan stops when a hit finds both the pending slot and the output full.
module ip_indicator_match_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	imt_cmd_if.sink                       cmd,
	imt_res_if.source                     res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [imt_pkg::PADDR_W-1:0]   paddr,
	input  logic [imt_pkg::PDATA_W-1:0]   pwdata,
	output logic [imt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CW      = $clog2(TABLE_DEPTH + 1);
	localparam int IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TAG_W   = imt_pkg::TAG_W;
	localparam int ADDR_W  = imt_pkg::ADDR_W;
	localparam int ENTRY_W = ADDR_W + TAG_W;

	imt_pkg::cfg_t    cfg;
	imt_pkg::state_t  state_q, state_d;
	imt_pkg::opcode_t op;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_idx_q;
	logic               s1_valid_q;
	logic [ADDR_W-1:0]  conn_addr_q;
	logic [TAG_W-1:0]   conn_tag_q;
	logic               pend_valid_q;
	logic               pend_kind_q;
	logic [TAG_W-1:0]   pend_ctag_q;
	logic [TAG_W-1:0]   pend_etag_q;
	logic               out_valid_q;
	logic               out_kind_q;
	logic [TAG_W-1:0]   out_ctag_q;
	logic [TAG_W-1:0]   out_etag_q;
	logic               out_last_q;
	logic [ENTRY_W-1:0] ram_rdata;

	logic cmd_acc, query_go, overflow, ins_ok, hit, rd_more, out_free;
	logic advance, issue, scan_end, found, is_idle, is_scan, is_flush;
	logic out_load_mid, out_load_last;

	imt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// decode of the incoming item
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign op       = imt_pkg::opcode_t'(cmd.opcode);
	assign overflow = cmd.entry_valid && (cnt_q == CW'(TABLE_DEPTH));
	assign ins_ok   = cmd_acc && (op == imt_pkg::OP_INSERT) && cmd.entry_valid && !overflow;
	assign query_go = cfg.feed_loaded && (cnt_q != '0) && cmd.conn_address_valid &&
	                  (!cfg.pid_filter_enable || (cmd.conn_pid == cfg.filter_pid));

	// scan control: a hit stalls only when the pending slot and output are both busy
	assign hit       = (ram_rdata[ENTRY_W-1:TAG_W] == conn_addr_q);
	assign rd_more   = (rd_idx_q != cnt_q);
	assign out_free  = !out_valid_q || res.ready;
	assign advance   = !(s1_valid_q && hit && pend_valid_q && !out_free);
	assign issue     = is_scan && advance && rd_more;
	assign scan_end  = is_scan && advance && !rd_more;
	assign found     = is_scan && advance && s1_valid_q && hit;
	assign out_load_mid  = found && pend_valid_q;
	assign out_load_last = is_flush && out_free;

	// entry store: address above tag
	imt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ins_ok),
		.waddr (cnt_q[IW-1:0]),
		.wdata ({cmd.entry_address, cmd.entry_tag}),
		.re    (issue),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imt_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					unique case (op)
						imt_pkg::OP_QUERY:  if (query_go) state_d = imt_pkg::ST_SCAN;
						imt_pkg::OP_INSERT: if (overflow) state_d = imt_pkg::ST_FLUSH;
						default: ;
					endcase
				end
			end
			imt_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = (pend_valid_q || found) ? imt_pkg::ST_FLUSH : imt_pkg::ST_IDLE;
				end
			end
			imt_pkg::ST_FLUSH: begin
				if (out_free) state_d = imt_pkg::ST_IDLE;
			end
			default: state_d = imt_pkg::ST_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		is_idle  = 1'b0;
		is_scan  = 1'b0;
		is_flush = 1'b0;
		unique case (state_q)
			imt_pkg::ST_IDLE:  is_idle  = 1'b1;
			imt_pkg::ST_SCAN:  is_scan  = 1'b1;
			imt_pkg::ST_FLUSH: is_flush = 1'b1;
			default: ;
		endcase
	end

	assign cmd.ready = is_idle;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= imt_pkg::ST_IDLE;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// entry count
			if (cmd_acc && (op == imt_pkg::OP_CLEAR)) begin
				cnt_q <= '0;
			end else if (ins_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end
			// read index and read stage
			if (cmd_acc) begin
				rd_idx_q   <= '0;
				s1_valid_q <= 1'b0;
			end else if (is_scan && advance) begin
				s1_valid_q <= issue;
				if (issue) rd_idx_q <= rd_idx_q + CW'(1);
			end
			// pending slot
			if (cmd_acc && (op == imt_pkg::OP_INSERT) && overflow) begin
				pend_valid_q <= 1'b1;
			end else if (found) begin
				pend_valid_q <= 1'b1;
			end else if (out_load_last) begin
				pend_valid_q <= 1'b0;
			end
			// output register
			if (out_load_mid || out_load_last) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			conn_addr_q <= cmd.conn_address;
			conn_tag_q  <= cmd.conn_tag;
		end
		if (cmd_acc && (op == imt_pkg::OP_INSERT) && overflow) begin
			pend_kind_q <= imt_pkg::KIND_OVERFLOW;
			pend_ctag_q <= '0;
			pend_etag_q <= cmd.entry_tag;
		end else if (found) begin
			pend_kind_q <= imt_pkg::KIND_MATCH;
			pend_ctag_q <= conn_tag_q;
			pend_etag_q <= ram_rdata[TAG_W-1:0];
		end
		if (out_load_mid || out_load_last) begin
			out_kind_q <= pend_kind_q;
			out_ctag_q <= pend_ctag_q;
			out_etag_q <= pend_etag_q;
			out_last_q <= out_load_last;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.result_kind     = out_kind_q;
	assign res.match_conn_tag  = out_ctag_q;
	assign res.match_entry_tag = out_etag_q;
	assign res.last_result     = out_last_q;

`ifndef NO_ASSERTIONS
	// the table never holds more than its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// no result is left behind when the engine goes idle
	a_idle_pend: assert property (@(posedge clk) disable iff (!arst_n)
		is_idle |-> !pend_valid_q)
		else $error("pending result while idle");

	// read stage only carries data during a scan
	a_s1_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> is_scan)
		else $error("read stage valid outside scan");

	// the read index never passes the count
	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		is_scan |-> (rd_idx_q <= cnt_q))
		else $error("read index beyond entry count");

	// the count holds while a scan runs
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		is_scan && $past(is_scan) |-> $stable(cnt_q))
		else $error("entry count changed during scan");
`endif

endmodule

FILE: tb/tb.sv
// self-checking testbench for the ip indicator match table
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH    = 64;
	localparam int RESET_CYCLES   = 8;
	// longest stretch with no result: a full scan without hits plus margin
	localparam int SETTLE_CYCLES  = TABLE_DEPTH + 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;
	localparam int POOL_MAX       = 8;

	// opcode that the block must ignore
	localparam logic [imt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [imt_pkg::OP_W-1:0]   op;
		logic [imt_pkg::ADDR_W-1:0] entry_address;
		logic                       entry_valid;
		logic [imt_pkg::TAG_W-1:0]  entry_tag;
		logic [imt_pkg::ADDR_W-1:0] conn_address;
		logic                       conn_address_valid;
		logic [imt_pkg::PID_W-1:0]  conn_pid;
		logic [imt_pkg::TAG_W-1:0]  conn_tag;
	} cmd_item_t;

	typedef struct {
		logic                      kind;
		logic [imt_pkg::TAG_W-1:0] conn_tag;
		logic [imt_pkg::TAG_W-1:0] entry_tag;
		logic                      is_last;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [imt_pkg::PADDR_W-1:0] paddr;
	logic [imt_pkg::PDATA_W-1:0] pwdata;
	logic [imt_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	imt_cmd_if cmd_ch();
	imt_res_if res_ch();

	ip_indicator_match_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial forever #6 clk = ~clk;

	// stimulus backlog and expected results
	cmd_item_t cmd_backlog[$];
	hit_t      expected_hits[$];
	int        items_queued = 0;
	int        items_taken = 0;
	int        fail_count = 0;
	int        quiet_cycles = 0;

	// shadow of the table and of the registers
	logic [imt_pkg::ADDR_W-1:0] tbl_addr[TABLE_DEPTH];
	logic [imt_pkg::TAG_W-1:0]  tbl_tag[TABLE_DEPTH];
	int                         tbl_count = 0;
	logic                       sh_feed = 1'b0;
	logic                       sh_pid_en = 1'b0;
	logic [imt_pkg::PID_W-1:0]  sh_pid = '0;

	// addresses that inserts and queries share so that lookups hit
	logic [imt_pkg::ADDR_W-1:0] addr_pool[POOL_MAX];
	int                         pool_size = 1;

	// idling knobs
	int tx_max_gap = 0;
	int tx_max_burst = 1;
	int rx_stall_pct = 0;
	int rx_max_stall = 1;

	int        burst_left = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	cmd_item_t tx_item;

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// expected results of one accepted item; updates the shadow table
	task automatic predict_lookup(input cmd_item_t it);
		hit_t found[$];
		hit_t h;
		case (it.op)
			imt_pkg::OP_CLEAR: tbl_count = 0;
			imt_pkg::OP_INSERT: begin
				if (it.entry_valid) begin
					if (tbl_count >= TABLE_DEPTH) begin
						h.kind = imt_pkg::KIND_OVERFLOW;
						h.conn_tag = '0;
						h.entry_tag = it.entry_tag;
						h.is_last = 1'b1;
						expected_hits.insert(expected_hits.size(), h);
					end else begin
						tbl_addr[tbl_count] = it.entry_address;
						tbl_tag[tbl_count] = it.entry_tag;
						tbl_count++;
					end
				end
			end
			imt_pkg::OP_QUERY: begin
				if (sh_feed && tbl_count != 0 && it.conn_address_valid &&
				    !(sh_pid_en && it.conn_pid != sh_pid)) begin
					for (int i = 0; i < tbl_count; i++) begin
						if (tbl_addr[i] == it.conn_address) begin
							h.kind = imt_pkg::KIND_MATCH;
							h.conn_tag = it.conn_tag;
							h.entry_tag = tbl_tag[i];
							h.is_last = 1'b0;
							found.insert(found.size(), h);
						end
					end
					if (found.size() != 0)
						found[found.size() - 1].is_last = 1'b1;
					foreach (found[i])
						expected_hits.insert(expected_hits.size(), found[i]);
				end
			end
			default: ;
		endcase
	endtask

	// apb write: setup cycle, then access cycle
	task automatic reg_write(input imt_pkg::reg_idx_t idx,
	                         input logic [imt_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= imt_pkg::PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			imt_pkg::REG_FEED_LOADED: sh_feed = value[0];
			imt_pkg::REG_PID_FILTER:  sh_pid_en = value[0];
			imt_pkg::REG_FILTER_PID:  sh_pid = value;
			default: ;
		endcase
	endtask

	// unused fields carry random noise
	function automatic cmd_item_t noise_item(input logic [imt_pkg::OP_W-1:0] op);
		cmd_item_t it;
		it.op = op;
		it.entry_address = $urandom;
		it.entry_valid = 1'($urandom_range(0, 1));
		it.entry_tag = 16'($urandom);
		it.conn_address = $urandom;
		it.conn_address_valid = 1'($urandom_range(0, 1));
		it.conn_pid = $urandom;
		it.conn_tag = 16'($urandom);
		return it;
	endfunction

	task automatic enqueue(input cmd_item_t it);
		cmd_backlog.insert(cmd_backlog.size(), it);
		items_queued++;
	endtask

	task automatic queue_op(input logic [imt_pkg::OP_W-1:0] op);
		enqueue(noise_item(op));
	endtask

	task automatic queue_insert(input logic [imt_pkg::ADDR_W-1:0] a, input logic v,
	                            input logic [imt_pkg::TAG_W-1:0] t);
		cmd_item_t it;
		it = noise_item(imt_pkg::OP_INSERT);
		it.entry_address = a;
		it.entry_valid = v;
		it.entry_tag = t;
		enqueue(it);
	endtask

	task automatic queue_query(input logic [imt_pkg::ADDR_W-1:0] a, input logic v,
	                           input logic [imt_pkg::PID_W-1:0] p,
	                           input logic [imt_pkg::TAG_W-1:0] t);
		cmd_item_t it;
		it = noise_item(imt_pkg::OP_QUERY);
		it.conn_address = a;
		it.conn_address_valid = v;
		it.conn_pid = p;
		it.conn_tag = t;
		enqueue(it);
	endtask

	task automatic refresh_pool(input int size);
		pool_size = size;
		for (int i = 0; i < size; i++)
			addr_pool[i] = $urandom;
		// now and then an all-zeros or all-ones address
		case ($urandom_range(0, 3))
			0: addr_pool[0] = '0;
			1: addr_pool[0] = '1;
			default: ;
		endcase
	endtask

	function automatic logic [imt_pkg::ADDR_W-1:0] pick_addr();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return addr_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	// pid that passes the filter most of the time when it is on
	function automatic logic [imt_pkg::PID_W-1:0] pick_pid();
		if (sh_pid_en && $urandom_range(0, 3) != 0)
			return sh_pid;
		return $urandom;
	endfunction

	// mixed random traffic, mostly inserts and queries
	task automatic queue_random(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				queue_op(imt_pkg::OP_CLEAR);
			else if (r < 5)
				queue_op(OP_UNUSED);
			else if (r < 50)
				queue_insert(pick_addr(), $urandom_range(0, 9) != 0, 16'($urandom));
			else
				queue_query(pick_addr(), $urandom_range(0, 9) != 0, pick_pid(),
				            16'($urandom));
		end
	endtask

	// wait for every item to be taken and every result to arrive
	task automatic wait_idle();
		while (items_taken != items_queued || expected_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int gap, input int burst, input int pct,
	                          input int stall);
		tx_max_gap = gap;
		tx_max_burst = burst;
		rx_stall_pct = pct;
		rx_max_stall = stall;
	endtask

	// command driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (gap_left > 0) begin
				cmd_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_backlog.size() != 0) begin
				tx_item = cmd_backlog.pop_front();
				cmd_ch.opcode <= tx_item.op;
				cmd_ch.entry_address <= tx_item.entry_address;
				cmd_ch.entry_valid <= tx_item.entry_valid;
				cmd_ch.entry_tag <= tx_item.entry_tag;
				cmd_ch.conn_address <= tx_item.conn_address;
				cmd_ch.conn_address_valid <= tx_item.conn_address_valid;
				cmd_ch.conn_pid <= tx_item.conn_pid;
				cmd_ch.conn_tag <= tx_item.conn_tag;
				cmd_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, tx_max_burst);
					gap_left <= (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stall runs
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
			res_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, rx_max_stall - 1);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// monitor: check results, then predict from the accepted item
	always @(posedge clk) begin
		hit_t got;
		hit_t want;
		cmd_item_t seen;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.kind = res_ch.result_kind;
				got.conn_tag = res_ch.match_conn_tag;
				got.entry_tag = res_ch.match_entry_tag;
				got.is_last = res_ch.last_result;
				if (expected_hits.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d entry tag %h",
					                          got.kind, got.entry_tag));
				end else begin
					want = expected_hits.pop_front();
					if (got.kind !== want.kind)
						report_mismatch($sformatf("result_kind %0d, want %0d",
						                          got.kind, want.kind));
					if (got.conn_tag !== want.conn_tag)
						report_mismatch($sformatf("match_conn_tag %h, want %h",
						                          got.conn_tag, want.conn_tag));
					if (got.entry_tag !== want.entry_tag)
						report_mismatch($sformatf("match_entry_tag %h, want %h",
						                          got.entry_tag, want.entry_tag));
					if (got.is_last !== want.is_last)
						report_mismatch($sformatf("last_result %0d, want %0d",
						                          got.is_last, want.is_last));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen.op = cmd_ch.opcode;
				seen.entry_address = cmd_ch.entry_address;
				seen.entry_valid = cmd_ch.entry_valid;
				seen.entry_tag = cmd_ch.entry_tag;
				seen.conn_address = cmd_ch.conn_address;
				seen.conn_address_valid = cmd_ch.conn_address_valid;
				seen.conn_pid = cmd_ch.conn_pid;
				seen.conn_tag = cmd_ch.conn_tag;
				predict_lookup(seen);
				items_taken++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [imt_pkg::ADDR_W-1:0] same_addr;
		// known values from time zero
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = imt_pkg::OP_CLEAR;
		cmd_ch.entry_address = '0;
		cmd_ch.entry_valid = 1'b0;
		cmd_ch.entry_tag = '0;
		cmd_ch.conn_address = '0;
		cmd_ch.conn_address_valid = 1'b0;
		cmd_ch.conn_pid = '0;
		cmd_ch.conn_tag = '0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases, no idling
		reg_write(imt_pkg::REG_FEED_LOADED, 1);
		reg_write(imt_pkg::REG_PID_FILTER, 0);
		reg_write(imt_pkg::REG_FILTER_PID, 0);
		set_idling(0, 1, 0, 1);
		queue_op(imt_pkg::OP_CLEAR);
		queue_query(32'h0000_0000, 1'b1, 32'h0, 16'h1111);     // empty table
		queue_insert(32'h0000_0000, 1'b1, 16'h0000);
		queue_insert(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		queue_insert(32'h1234_5678, 1'b0, 16'hAAAA);           // invalid, ignored
		queue_insert(32'h0000_0000, 1'b1, 16'h5555);           // duplicate address
		queue_op(OP_UNUSED);
		queue_query(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 16'hFFFF); // two hits
		queue_query(32'hFFFF_FFFF, 1'b1, 32'h0, 16'h0000);
		queue_query(32'h0000_0000, 1'b0, 32'h0, 16'h2222);     // address not valid
		queue_query(32'h1234_5678, 1'b1, 32'h0, 16'h3333);
		queue_query(32'h7FFF_FFFF, 1'b1, 32'h0, 16'h4444);
		queue_op(imt_pkg::OP_CLEAR);
		queue_query(32'h0000_0000, 1'b1, 32'h0, 16'h6666);     // cleared table
		queue_insert(32'hC0A8_0001, 1'b1, 16'h0001);
		queue_query(32'hC0A8_0001, 1'b1, 32'h8000_0000, 16'h8000);
		queue_insert(32'h8000_0000, 1'b1, 16'h8000);
		queue_query(32'h8000_0000, 1'b1, 32'h0000_0001, 16'h7FFF);
		wait_idle();

		// random traffic, moderate idling
		set_idling(6, 12, 30, 8);
		refresh_pool(8);
		queue_random(150);
		wait_idle();

		// pid filter on; fill the table and overflow it
		reg_write(imt_pkg::REG_PID_FILTER, 1);
		reg_write(imt_pkg::REG_FILTER_PID, 32'hFFFF_FFFF);
		set_idling(15, 20, 50, 15);
		refresh_pool(4);
		queue_op(imt_pkg::OP_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++)
			queue_insert(pick_addr(), 1'b1, 16'($urandom));
		queue_insert($urandom, 1'b1, 16'h0000);
		queue_insert($urandom, 1'b0, 16'h1234);                // invalid while full
		queue_insert($urandom, 1'b1, 16'hFFFF);
		queue_query(addr_pool[0], 1'b1, 32'hFFFF_FFFF, 16'($urandom));
		queue_query(addr_pool[0], 1'b1, 32'h0000_0000, 16'($urandom)); // filtered out
		queue_query(tbl_addr[0], 1'b1, 32'hFFFF_FFFF, 16'($urandom));
		for (int i = 0; i < 20; i++)
			queue_query(pick_addr(), 1'b1, pick_pid(), 16'($urandom));
		queue_insert($urandom, 1'b1, 16'($urandom));
		wait_idle();

		// feed not loaded: queries are silent, overflow still reported
		reg_write(imt_pkg::REG_FEED_LOADED, 0);
		reg_write(imt_pkg::REG_FILTER_PID, 0);
		set_idling(3, 8, 10, 4);
		refresh_pool(6);
		queue_query(pick_addr(), 1'b1, 32'h0, 16'($urandom));
		queue_random(40);
		wait_idle();

		// feed loaded, filter on a random pid
		reg_write(imt_pkg::REG_FEED_LOADED, 1);
		reg_write(imt_pkg::REG_FILTER_PID, $urandom);
		set_idling(4, 6, 20, 6);
		refresh_pool(8);
		queue_op(imt_pkg::OP_CLEAR);
		queue_random(120);
		wait_idle();

		// filter off; every entry on one address so a query returns the full table
		reg_write(imt_pkg::REG_PID_FILTER, 0);
		reg_write(imt_pkg::REG_FILTER_PID, $urandom);
		set_idling(2, 30, 40, 20);
		refresh_pool(3);
		same_addr = $urandom;
		queue_op(imt_pkg::OP_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++)
			queue_insert(same_addr, 1'b1, 16'($urandom));
		queue_insert(same_addr, 1'b1, 16'($urandom));
		for (int i = 0; i < 4; i++)
			queue_query(same_addr, 1'b1, $urandom, 16'($urandom));
		queue_random(10);
		wait_idle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
